[hdl/cdg_pkg.sv]
// ----------------------------------------------------------------------------
// Cash dispenser package
// Widths, denomination tables and shared types for the greedy dispenser.
// ----------------------------------------------------------------------------
`default_nettype none

package cdg_pkg;

    // Stock counter width and number of note denominations.
    localparam int COUNT_WIDTH = 16;
    localparam int NUM_DENOMS  = 7;
    localparam int IDX_W       = 3;

    // Field widths of the request and result items.
    localparam int AMOUNT_W = 24;
    localparam int FIELD_W  = 16;
    localparam int DENOM_W  = 7;

    // Reciprocal multiplier width and derived arithmetic widths.
    localparam int MULT_W = 25;
    localparam int PROD_W = AMOUNT_W + MULT_W;
    localparam int CMP_W  = (AMOUNT_W > COUNT_WIDTH) ? AMOUNT_W : COUNT_WIDTH;
    localparam int SUM_W  = ((COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W) + 1;
    localparam int TAKE_W = COUNT_WIDTH + DENOM_W;
    localparam int DEP_W  = FIELD_W + DENOM_W;

    // Saturation limit of a stock counter, held at the adder width.
    localparam logic [SUM_W-1:0] COUNT_MAX_EXT = (SUM_W'(1) << COUNT_WIDTH) - SUM_W'(1);

    // Stream data widths, padded to whole bytes.
    localparam int IN_DATA_W  = AMOUNT_W + NUM_DENOMS * FIELD_W;
    localparam int OUT_BITS   = 1 + AMOUNT_W + NUM_DENOMS * FIELD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int USED_LO    = 1 + AMOUNT_W;

    // Request kinds and result status codes.
    localparam logic OP_WITHDRAW  = 1'b0;
    localparam logic OP_DEPOSIT   = 1'b1;
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    // Note values, largest first.
    localparam logic [DENOM_W-1:0] DENOM_VALUE [NUM_DENOMS] = '{
        7'd100, 7'd50, 7'd20, 7'd10, 7'd5, 7'd2, 7'd1
    };

    // Exact floor division of a 24-bit value: q = (x * M) >> S.
    localparam logic [MULT_W-1:0] RECIP_MULT [NUM_DENOMS] = '{
        25'd21474837, 25'd21474837, 25'd26843546, 25'd26843546,
        25'd26843546, 25'd16777216, 25'd16777216
    };
    localparam int RECIP_SHIFT [NUM_DENOMS] = '{31, 30, 29, 28, 27, 25, 24};

    // Token that walks the cell chain: remaining amount or running deposit total.
    typedef struct packed {
        logic                valid;
        logic                op;
        logic [AMOUNT_W-1:0] val;
    } cdg_link_t;

endpackage

`default_nettype wire

[hdl/cdg_cell.sv]
// ----------------------------------------------------------------------------
// Dispenser denomination cell
// Holds the stock of one note value and handles the request token in two
// stages: a reciprocal divide, then the greedy take or the deposit add.
// ----------------------------------------------------------------------------
`default_nettype none

module cdg_cell
    import cdg_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [IDX_W-1:0]       denom_idx,
    input  wire cdg_link_t              link_in,
    input  wire logic [FIELD_W-1:0]     dep_count,
    input  wire logic                   apply_withdraw,
    output      cdg_link_t              link_out,
    output      logic [COUNT_WIDTH-1:0] used_count
);

    logic                   s1_valid_reg;
    logic                   s1_op_reg;
    logic [AMOUNT_W-1:0]    s1_val_reg;
    logic [AMOUNT_W-1:0]    s1_quot_reg;
    logic                   s2_valid_reg;
    logic                   s2_op_reg;
    logic [AMOUNT_W-1:0]    s2_val_reg;
    logic [COUNT_WIDTH-1:0] stock_reg;
    logic [COUNT_WIDTH-1:0] stock_next;
    logic [COUNT_WIDTH-1:0] used_reg;

    logic [PROD_W-1:0]      quot_prod;
    logic [PROD_W-1:0]      quot_shift;
    logic [CMP_W-1:0]       take_cmp;
    logic [COUNT_WIDTH-1:0] take;
    logic [TAKE_W-1:0]      take_val;
    logic [DEP_W-1:0]       dep_val;
    logic [SUM_W-1:0]       stock_sum;
    logic [AMOUNT_W-1:0]    s2_val_next;

    // Stage one: floor(amount / note value) by reciprocal multiplication.
    assign quot_prod  = PROD_W'(link_in.val) * PROD_W'(RECIP_MULT[denom_idx]);
    assign quot_shift = quot_prod >> RECIP_SHIFT[denom_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= link_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (link_in.valid) begin
            s1_op_reg   <= link_in.op;
            s1_val_reg  <= link_in.val;
            s1_quot_reg <= quot_shift[AMOUNT_W-1:0];
        end
    end

    // Stage two: greedy take limited by the stock, or the deposit value.
    assign take_cmp = (CMP_W'(s1_quot_reg) < CMP_W'(stock_reg)) ?
                      CMP_W'(s1_quot_reg) : CMP_W'(stock_reg);
    assign take     = take_cmp[COUNT_WIDTH-1:0];
    assign take_val = TAKE_W'(take) * TAKE_W'(DENOM_VALUE[denom_idx]);
    assign dep_val  = DEP_W'(dep_count) * DEP_W'(DENOM_VALUE[denom_idx]);

    always_comb begin
        if (s1_op_reg == OP_DEPOSIT) begin
            s2_val_next = s1_val_reg + AMOUNT_W'(dep_val);
        end else begin
            s2_val_next = s1_val_reg - AMOUNT_W'(take_val);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_op_reg  <= s1_op_reg;
            s2_val_reg <= s2_val_next;
            used_reg   <= (s1_op_reg == OP_WITHDRAW) ? take : '0;
        end
    end

    // Stock: saturating add on a deposit, subtract on a successful withdrawal.
    assign stock_sum = SUM_W'(stock_reg) + SUM_W'(dep_count);

    always_comb begin
        stock_next = stock_reg;
        if (s1_valid_reg && (s1_op_reg == OP_DEPOSIT)) begin
            if (stock_sum > COUNT_MAX_EXT) begin
                stock_next = COUNT_MAX_EXT[COUNT_WIDTH-1:0];
            end else begin
                stock_next = stock_sum[COUNT_WIDTH-1:0];
            end
        end else if (apply_withdraw) begin
            stock_next = stock_reg - used_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stock_reg <= '0;
        end else begin
            stock_reg <= stock_next;
        end
    end

    assign link_out.valid = s2_valid_reg;
    assign link_out.op    = s2_op_reg;
    assign link_out.val   = s2_val_reg;
    assign used_count     = used_reg;

endmodule

`default_nettype wire

[hdl/cash_dispense_greedy_unit.sv]
// A request walks a chain of seven denomination cells, two register stages per
// cell, and one request is in flight at a time: the next request is taken only
// after the last one has left the chain and its result is committed. A waiting
// result does not block the next request.
// Reset: aresetn (synchronous, active low) clears every stock count to zero.
// ----------------------------------------------------------------------------
// Greedy cash dispenser
// Keeps note stock per denomination, takes deposits and serves withdrawals
// largest note first, leaving the stock unchanged when a withdrawal fails.
// ----------------------------------------------------------------------------
`default_nettype none

module cash_dispense_greedy_unit
    import cdg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    // amount, dep_hundred, dep_fifty, dep_twenty, dep_ten, dep_five, dep_two,
    // dep_one
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  wire logic                  s_axis_tuser,
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status, deposit_value, used_hundred, used_fifty, used_twenty, used_ten,
    // used_five, used_two, used_one, zero padding
    output      logic [OUT_DATA_W-1:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } cdg_state_t;

    cdg_state_t             state_reg;
    cdg_state_t             state_next;
    logic                   ready_reg;
    logic                   accept;
    logic                   out_free;
    logic                   commit;
    logic                   apply_withdraw;
    logic                   m_valid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;
    logic [OUT_DATA_W-1:0]  m_data_next;
    logic [FIELD_W-1:0]     dep_reg [NUM_DENOMS];
    logic [COUNT_WIDTH-1:0] used_count [NUM_DENOMS];
    cdg_link_t              link [NUM_DENOMS+1];
    cdg_link_t              fin;

    assign accept        = s_axis_tvalid && ready_reg;
    assign s_axis_tready = ready_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Deposit counts stay registered for the cells to read as the token passes.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < NUM_DENOMS; k++) begin
                dep_reg[k] <= s_axis_tdata[AMOUNT_W + k*FIELD_W +: FIELD_W];
            end
        end
    end

    // Token entering the chain: withdraw amount, or a zero deposit total.
    assign link[0].valid = accept;
    assign link[0].op    = s_axis_tuser;
    assign link[0].val   = (s_axis_tuser == OP_DEPOSIT) ? '0 : s_axis_tdata[AMOUNT_W-1:0];

    generate
        for (genvar k = 0; k < NUM_DENOMS; k++) begin : g_cell
            cdg_cell u_cell (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .denom_idx      (IDX_W'(k)),
                .link_in        (link[k]),
                .dep_count      (dep_reg[k]),
                .apply_withdraw (apply_withdraw),
                .link_out       (link[k+1]),
                .used_count     (used_count[k])
            );
        end
    endgenerate

    assign fin = link[NUM_DENOMS];

    // Sequencer: wait for the token to leave the chain and for a free output slot.
    always_comb begin
        state_next = state_reg;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (fin.valid) begin
                    if (out_free) begin
                        commit     = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    // A withdrawal commits only when nothing of the amount is left over.
    assign apply_withdraw = commit && (fin.op == OP_WITHDRAW) && (fin.val == '0);

    // Result packing.
    always_comb begin
        m_data_next = '0;
        if (fin.op == OP_DEPOSIT) begin
            m_data_next[0]          = STATUS_DONE;
            m_data_next[AMOUNT_W:1] = fin.val;
        end else if (fin.val != '0) begin
            m_data_next[0] = STATUS_SHORT;
        end else begin
            m_data_next[0] = STATUS_DONE;
            for (int k = 0; k < NUM_DENOMS; k++) begin
                m_data_next[USED_LO + k*FIELD_W +: FIELD_W] = FIELD_W'(used_count[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

[hdl/cdg_checker.sv]
// ----------------------------------------------------------------------------
// Dispenser port checker
// Watches the stream ports of the dispenser and flags illegal behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module cdg_checker
    import cdg_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int USED_HI = USED_LO + NUM_DENOMS * FIELD_W - 1;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Only one request is in flight: ready drops after an accepted request.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // A result never appears in the cycle right after its request.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

    // A short withdrawal dispenses nothing and reports no deposit.
    a_short_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[0] == STATUS_SHORT) |->
            (m_axis_tdata[USED_HI:1] == '0))
        else $error("short withdrawal carries data");

    // A deposit result dispenses no notes.
    a_deposit_no_notes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[AMOUNT_W:1] != '0) |->
            (m_axis_tdata[USED_HI:USED_LO] == '0))
        else $error("deposit result reports dispensed notes");

endmodule

bind cash_dispense_greedy_unit cdg_checker u_cdg_checker (.*);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greedy cash dispenser testbench
// Sends deposit and withdrawal requests to the dispenser and keeps its own
// note stock to work out each expected result. Every result is checked field
// by field, in order, while both stream sides stall at random and once
// through a long output hold-off.
// ----------------------------------------------------------------------------

module tb;
    import cdg_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;

    // Denomination slots, largest note first.
    localparam int DEN_FIFTY  = 1;
    localparam int DEN_TWENTY = 2;

    localparam longint unsigned COUNT_FULL = (64'd1 << COUNT_WIDTH) - 64'd1;

    typedef logic [NUM_DENOMS-1:0][FIELD_W-1:0] note_counts_t;

    typedef struct packed {
        logic                op;
        logic [AMOUNT_W-1:0] amount;
        note_counts_t        notes;
    } teller_req_t;

    typedef struct packed {
        logic                status;
        logic [AMOUNT_W-1:0] deposit_value;
        note_counts_t        used;
    } payout_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // amount, dep_hundred, dep_fifty, dep_twenty, dep_ten, dep_five, dep_two,
    // dep_one
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // opcode
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // status, deposit_value, used_hundred, used_fifty, used_twenty, used_ten,
    // used_five, used_two, used_one, zero padding
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Bench copy of the note stock and the payouts still owed.
    logic [COUNT_WIDTH-1:0] note_stock [NUM_DENOMS] = '{default: '0};
    payout_t                pending_payouts [$];

    int     error_count  = 0;
    int     tx_idle_pct  = 0;
    int     rx_idle_pct  = 0;
    int     hold_request = 0;
    int     rx_hold_left = 0;
    longint cycle_count  = 0;
    string  note_name [NUM_DENOMS] = '{"hundred", "fifty", "twenty", "ten",
                                       "five", "two", "one"};

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    cash_dispense_greedy_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Works out the payout of one request and updates the bench stock.
    function automatic payout_t predict_payout(teller_req_t req);
        payout_t         res;
        longint unsigned left;
        longint unsigned need;
        longint unsigned sum;
        longint unsigned total;
        longint unsigned take [NUM_DENOMS];
        res = '0;
        if (req.op == OP_DEPOSIT) begin
            // Counts saturate, but the reported value covers every note offered.
            total = 0;
            for (int k = 0; k < NUM_DENOMS; k++) begin
                sum = 64'(note_stock[k]) + 64'(req.notes[k]);
                if (sum > COUNT_FULL) begin
                    sum = COUNT_FULL;
                end
                note_stock[k] = COUNT_WIDTH'(sum);
                total = total + 64'(req.notes[k]) * DENOM_VALUE[k];
            end
            res.status        = STATUS_DONE;
            res.deposit_value = AMOUNT_W'(total);
        end else begin
            // Largest note first, limited by what is on hand.
            left = req.amount;
            for (int k = 0; k < NUM_DENOMS; k++) begin
                need    = left / DENOM_VALUE[k];
                take[k] = (need < note_stock[k]) ? need : 64'(note_stock[k]);
                left    = left - take[k] * DENOM_VALUE[k];
            end
            if (left != 0) begin
                // A shortfall dispenses nothing and leaves the stock alone.
                res.status = STATUS_SHORT;
            end else begin
                res.status = STATUS_DONE;
                for (int k = 0; k < NUM_DENOMS; k++) begin
                    note_stock[k] = note_stock[k] - COUNT_WIDTH'(take[k]);
                    res.used[k]   = FIELD_W'(take[k]);
                end
            end
        end
        return res;
    endfunction

    function automatic longint unsigned stock_value();
        longint unsigned v;
        v = 0;
        for (int k = 0; k < NUM_DENOMS; k++) begin
            v = v + 64'(note_stock[k]) * DENOM_VALUE[k];
        end
        return v;
    endfunction

    function automatic note_counts_t same_notes(logic [FIELD_W-1:0] count);
        note_counts_t notes;
        for (int k = 0; k < NUM_DENOMS; k++) begin
            notes[k] = count;
        end
        return notes;
    endfunction

    function automatic teller_req_t make_request(logic op, logic [AMOUNT_W-1:0] amount,
                                                 note_counts_t notes);
        teller_req_t req;
        req.op     = op;
        req.amount = amount;
        req.notes  = notes;
        return req;
    endfunction

    // Random request shaped by the current stock, so that withdrawals
    // succeed, drain the stock and fall short in a useful mix.
    function automatic teller_req_t random_request();
        teller_req_t     req;
        longint unsigned v;
        int              pick;
        int              lone;
        req.amount = AMOUNT_W'($urandom);
        for (int k = 0; k < NUM_DENOMS; k++) begin
            req.notes[k] = FIELD_W'($urandom);
        end
        pick = $urandom_range(99);
        if ($urandom_range(99) < 35) begin
            req.op = OP_DEPOSIT;
            if (pick < 75) begin
                for (int k = 0; k < NUM_DENOMS; k++) begin
                    req.notes[k] = FIELD_W'($urandom_range(20));
                end
            end else if (pick >= 90) begin
                lone = $urandom_range(NUM_DENOMS - 1);
                for (int k = 0; k < NUM_DENOMS; k++) begin
                    if (k != lone) begin
                        req.notes[k] = '0;
                    end
                end
            end
        end else begin
            req.op = OP_WITHDRAW;
            v = stock_value();
            if (pick < 35) begin
                req.amount = AMOUNT_W'($urandom_range(32'(v)));
            end else if (pick < 50) begin
                req.amount = AMOUNT_W'(v);
            end else if (pick < 70) begin
                req.amount = AMOUNT_W'($urandom_range(999));
            end else if (pick >= 85) begin
                req.amount = AMOUNT_W'(v + $urandom_range(100, 1));
            end
        end
        return req;
    endfunction

    // Offers one request from a falling edge until it is taken, records its
    // payout, then drops valid and idles at random.
    task automatic send_request(teller_req_t req);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req.op;
        s_axis_tdata  = {req.notes, req.amount};
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        pending_payouts.push_back(predict_payout(req));
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
        end
    endtask

    function automatic void flag_mismatch(string what, longint unsigned want_val,
                                          longint unsigned got_val);
        error_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d",
                 $time, what, want_val, got_val);
    endfunction

    // Withdrawals against an empty stock.
    task automatic test_empty_stock();
        send_request(make_request(OP_WITHDRAW, '0, same_notes('0)));
        send_request(make_request(OP_WITHDRAW, 24'd1, same_notes('0)));
        send_request(make_request(OP_WITHDRAW, '1, same_notes('1)));
    endtask

    // Greedy choice falls short although a smaller set of notes would do.
    task automatic test_greedy_shortfall();
        teller_req_t req;
        req = make_request(OP_DEPOSIT, '0, same_notes('0));
        req.notes[DEN_FIFTY]  = 16'd1;
        req.notes[DEN_TWENTY] = 16'd3;
        send_request(req);
        send_request(make_request(OP_WITHDRAW, 24'd60, same_notes('0)));
        send_request(make_request(OP_WITHDRAW, 24'd110, same_notes('0)));
    endtask

    // Full stock, saturation, a shortfall on a full stock and a complete drain.
    task automatic test_saturation();
        send_request(make_request(OP_DEPOSIT, '0, same_notes('0)));
        send_request(make_request(OP_DEPOSIT, '1, same_notes('1)));
        send_request(make_request(OP_DEPOSIT, '0, same_notes(16'd1)));
        send_request(make_request(OP_WITHDRAW, '1, same_notes('0)));
        send_request(make_request(OP_WITHDRAW, 24'd388, same_notes('0)));
        send_request(make_request(OP_WITHDRAW, AMOUNT_W'(stock_value()), same_notes('0)));
        send_request(make_request(OP_WITHDRAW, 24'd1, same_notes('0)));
    endtask

    // Alternating bit patterns in every field, used or not.
    task automatic test_bit_patterns();
        send_request(make_request(OP_DEPOSIT, 24'h555555, same_notes(16'hAAAA)));
        send_request(make_request(OP_DEPOSIT, 24'hAAAAAA, same_notes(16'h5555)));
        send_request(make_request(OP_WITHDRAW, 24'hAAAAAA, same_notes(16'h5555)));
        send_request(make_request(OP_WITHDRAW, 24'h555555, same_notes(16'hAAAA)));
    endtask

    // The sink holds off long enough for the block to fill and stall its input.
    task automatic test_output_stall();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = HOLD_CYCLES;
        repeat (20) begin
            send_request(random_request());
        end
    endtask

    task automatic run_random_traffic(int count, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) begin
            send_request(random_request());
        end
    endtask

    // Long sink hold-off, counted here and read by the sink driver.
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            rx_hold_left <= hold_request;
            hold_request = 0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Sink side ready, changed at the falling edge.
    always @(negedge aclk) begin
        m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // Result checker: each taken result against the oldest payout owed.
    always @(posedge aclk) begin
        payout_t got;
        payout_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status        = m_axis_tdata[0];
            got.deposit_value = m_axis_tdata[1 +: AMOUNT_W];
            for (int k = 0; k < NUM_DENOMS; k++) begin
                got.used[k] = m_axis_tdata[USED_LO + k * FIELD_W +: FIELD_W];
            end
            if (pending_payouts.size() == 0) begin
                error_count++;
                $display("%0t: result with no request outstanding, status %0d",
                         $time, got.status);
            end else begin
                want = pending_payouts.pop_front();
                if (got.status != want.status) begin
                    flag_mismatch("status", want.status, got.status);
                end
                if (got.deposit_value != want.deposit_value) begin
                    flag_mismatch("deposit_value", want.deposit_value, got.deposit_value);
                end
                for (int k = 0; k < NUM_DENOMS; k++) begin
                    if (got.used[k] != want.used[k]) begin
                        flag_mismatch({"used_", note_name[k]}, want.used[k], got.used[k]);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        tx_idle_pct = 13;
        rx_idle_pct = 61;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_stock();
        test_greedy_shortfall();
        test_saturation();
        test_bit_patterns();
        run_random_traffic(600, 13, 61);
        run_random_traffic(600, 61, 13);
        test_output_stall();
        run_random_traffic(500, 0, 0);

        // Let every owed payout arrive, then watch for stray results.
        while (pending_payouts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/cdg_pkg.sv
hdl/cdg_cell.sv
hdl/cash_dispense_greedy_unit.sv
hdl/cdg_checker.sv
bench/tb.sv
